// ===== sv/rrp_pkg.sv =====
// Shared types and constants for the rectangle raster painter.
// No dependencies; every other file imports it.
package rrp_pkg;

  localparam int COORD_W = 24;
  localparam int CHAR_W  = 8;
  localparam int PIX_W   = 9;
  localparam int DIMC_W  = 10;
  localparam int FIX_W   = 32;

  typedef logic signed [FIX_W-1:0] fix_t;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_DRAW  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BGCHAR = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_DRAW,
    CMD_READ,
    CMD_REPORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [1:0]          status;
    logic                solid;
    logic [CHAR_W-1:0]   fill_char;
    logic [PIX_W-1:0]    col;
    logic [PIX_W-1:0]    row;
    fix_t                x_lo;
    fix_t                x_hi;
    fix_t                x_in_lo;
    fix_t                x_in_hi;
    fix_t                y_lo;
    fix_t                y_hi;
    fix_t                y_in_lo;
    fix_t                y_in_hi;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_LOOKUP,
    BK_FETCH,
    BK_FINISH
  } back_state_t;

endpackage

// ===== sv/rrp_in_if.sv =====
// Request channel of the rectangle raster painter: valid/ready plus request fields.
// Depends on rrp_pkg.
interface rrp_in_if;
  import rrp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic                       solid_fill;
  logic signed [COORD_W-1:0]  rect_x;
  logic signed [COORD_W-1:0]  rect_y;
  logic signed [COORD_W-1:0]  rect_w;
  logic signed [COORD_W-1:0]  rect_h;
  logic [CHAR_W-1:0]          paint_char;
  logic [PIX_W-1:0]           pixel_col;
  logic [PIX_W-1:0]           pixel_row;

  modport source (
    output valid, req_type, solid_fill, rect_x, rect_y, rect_w, rect_h,
           paint_char, pixel_col, pixel_row,
    input  ready
  );

  modport sink (
    input  valid, req_type, solid_fill, rect_x, rect_y, rect_w, rect_h,
           paint_char, pixel_col, pixel_row,
    output ready
  );
endinterface

// ===== sv/rrp_out_if.sv =====
// Result channel of the rectangle raster painter: valid/ready plus status and cell.
// Depends on rrp_pkg.
interface rrp_out_if;
  import rrp_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [CHAR_W-1:0] cell_char;

  modport source (output valid, status, cell_char, input ready);
  modport sink (input valid, status, cell_char, output ready);
endinterface

// ===== sv/rrp_front.sv =====
// Front end: accepts request items, checks them and turns them into queue commands.
// Depends on rrp_pkg and rrp_in_if.
module rrp_front #(
  parameter int MAX_DIM   = 512,
  parameter int FRAC_BITS = 8,
  parameter int DW        = $clog2(MAX_DIM + 1)
) (
  rrp_in_if.sink                req,
  input  logic [DW-1:0]         eff_w,
  input  logic [DW-1:0]         eff_h,
  input  logic [rrp_pkg::CHAR_W-1:0] bg_char,
  input  logic                  q_full,
  output logic                  push,
  output rrp_pkg::cmd_t         cmd
);
  import rrp_pkg::*;

  localparam fix_t ONE = fix_t'(1) << FRAC_BITS;

  fix_t rx, ry, rw, rh;
  logic empty_canvas;
  logic outside;

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  assign rx = fix_t'(req.rect_x);
  assign ry = fix_t'(req.rect_y);
  assign rw = fix_t'(req.rect_w);
  assign rh = fix_t'(req.rect_h);

  assign empty_canvas = (eff_w == '0) || (eff_h == '0);
  assign outside = (32'(req.pixel_col) >= 32'(eff_w)) ||
                   (32'(req.pixel_row) >= 32'(eff_h));

  always_comb begin
    cmd.solid     = req.solid_fill;
    cmd.col       = req.pixel_col;
    cmd.row       = req.pixel_row;
    cmd.x_lo      = rx;
    cmd.x_hi      = rx + rw;
    cmd.x_in_lo   = rx + ONE;
    cmd.x_in_hi   = rx + rw - ONE;
    cmd.y_lo      = ry;
    cmd.y_hi      = ry + rh;
    cmd.y_in_lo   = ry + ONE;
    cmd.y_in_hi   = ry + rh - ONE;
    cmd.fill_char = req.paint_char;
    cmd.status    = ST_OK;
    cmd.kind      = CMD_REPORT;
    unique case (req.req_type)
      REQ_CLEAR: begin
        cmd.fill_char = bg_char;
        cmd.kind      = empty_canvas ? CMD_REPORT : CMD_CLEAR;
      end
      REQ_DRAW: begin
        if (rw <= 0 || rh <= 0) begin
          cmd.status = ST_BAD_SIZE;
        end else if (!empty_canvas) begin
          cmd.kind = CMD_DRAW;
        end
      end
      REQ_READ: begin
        if (outside) begin
          cmd.status = ST_OUTSIDE;
        end else begin
          cmd.kind = CMD_READ;
        end
      end
      default: begin
        cmd.kind = CMD_REPORT;
      end
    endcase
  end
endmodule

// ===== sv/rrp_queue.sv =====
// Small command queue between the front end and the back end.
// Depends on rrp_pkg.
module rrp_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rrp_pkg::cmd_t push_cmd,
  input  logic          pop,
  output rrp_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import rrp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  cmd_t            entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign full  = (32'(count) == 32'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(DEPTH)) else $error("queue count out of range");
`endif
endmodule

// ===== sv/rrp_back.sv =====
// Back end: sweeps the canvas memory for clear and draw, serves reads, holds the result.
// Depends on rrp_pkg and rrp_out_if.
module rrp_back #(
  parameter int MAX_DIM   = 512,
  parameter int FRAC_BITS = 8,
  parameter int DW        = $clog2(MAX_DIM + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [DW-1:0] eff_w,
  input  logic [DW-1:0] eff_h,
  input  rrp_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          pop,
  rrp_out_if.source     rsp
);
  import rrp_pkg::*;

  localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  back_state_t       state, state_next;
  cmd_t              cur;
  logic [CW-1:0]     col;
  logic [CW-1:0]     row;
  logic [AW-1:0]     addr_cnt;
  logic [AW-1:0]     rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic [CHAR_W-1:0] mem [CELLS];

  logic              out_valid;
  logic [1:0]        out_status;
  logic [CHAR_W-1:0] out_cell;

  fix_t px, py;
  logic last_col, last_row;
  logic in_rect, on_edge;
  logic wr_en;
  logic load_out;

  assign px = fix_t'(col) << FRAC_BITS;
  assign py = fix_t'(row) << FRAC_BITS;
  assign last_col = (32'(col) + 32'd1) == 32'(eff_w);
  assign last_row = (32'(row) + 32'd1) == 32'(eff_h);
  assign in_rect = (px >= cur.x_lo) && (px <= cur.x_hi) &&
                   (py >= cur.y_lo) && (py <= cur.y_hi);
  assign on_edge = (px < cur.x_in_lo) || (px > cur.x_in_hi) ||
                   (py < cur.y_in_lo) || (py > cur.y_in_hi);

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.cell_char = out_cell;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          unique case (head.kind)
            CMD_CLEAR, CMD_DRAW: state_next = BK_SWEEP;
            CMD_READ:            state_next = BK_LOOKUP;
            CMD_REPORT:          state_next = BK_FINISH;
          endcase
        end
      end
      BK_SWEEP: begin
        if (last_col && last_row) state_next = BK_FINISH;
      end
      BK_LOOKUP: state_next = BK_FETCH;
      BK_FETCH:  state_next = BK_FINISH;
      BK_FINISH: begin
        if (!out_valid || rsp.ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    wr_en    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      BK_IDLE:   pop = !q_empty;
      BK_SWEEP:  wr_en = (cur.kind == CMD_CLEAR) ||
                         (in_rect && (cur.solid || on_edge));
      BK_FINISH: load_out = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_cnt] <= cur.fill_char;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == BK_LOOKUP) begin
      rd_addr <= AW'(32'(cur.row) * 32'(eff_w) + 32'(cur.col));
    end
    if (load_out) begin
      out_status <= cur.status;
      out_cell   <= (cur.kind == CMD_READ) ? rd_data : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      col       <= '0;
      row       <= '0;
      addr_cnt  <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        col      <= '0;
        row      <= '0;
        addr_cnt <= '0;
      end else if (state == BK_SWEEP) begin
        addr_cnt <= addr_cnt + AW'(1);
        if (last_col) begin
          col <= '0;
          row <= row + CW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

`ifndef SYNTH
  a_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == BK_SWEEP) else $error("canvas write outside sweep");
  a_sweep_addr: assert property (@(posedge clk) disable iff (rst)
    state == BK_SWEEP |->
      32'(addr_cnt) == 32'(row) * 32'(eff_w) + 32'(col))
    else $error("sweep address out of step with row and column");
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == BK_FINISH)
    else $error("result raised outside finish state");
  a_sweep_bounds: assert property (@(posedge clk) disable iff (rst)
    state == BK_SWEEP |-> 32'(col) < 32'(eff_w) && 32'(row) < 32'(eff_h))
    else $error("sweep outside canvas");
`endif
endmodule

// ===== sv/rectangle_raster_painter.sv =====
// Top level of the rectangle raster painter: configuration registers, front end,
// command queue and back end. Depends on rrp_pkg, rrp_in_if, rrp_out_if and the rrp_* modules.
//
// Use: request items arrive on req (clear, draw rectangle, read one cell) and
// each produces exactly one result item on rsp (status, cell_char), in order.
// Canvas size and background character are set through the APB port at
// byte addresses 0 (width), 4 (height) and 8 (background); the user must set
// them only while idle, as the block does not enforce it. Sizes above
// MAX_DIM act as MAX_DIM. Reset sets 512 x 512 and a space background;
// the canvas content is undefined until the first clear.
// Flow, from the accepting edge to rsp.valid with an idle back end: a clear
// or draw sweeps the canvas memory one cell per cycle (queue pop, sweep,
// result load); a read goes through queue pop, address multiply, registered
// memory read and result load; a rejected or unused request goes through
// queue pop and result load. Items are handled one at a time by the back end.
// A two-entry command queue lets the front accept new items while the back
// is busy or its result waits; if rsp.ready stays low the result register
// holds, then the queue fills and req.ready drops.
module rectangle_raster_painter #(
  parameter int MAX_DIM   = 512,
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  rrp_in_if.sink      req,
  rrp_out_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rrp_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);

  logic [DIMC_W-1:0] cfg_width;
  logic [DIMC_W-1:0] cfg_height;
  logic [CHAR_W-1:0] cfg_bg;
  logic [DW-1:0]     eff_w;
  logic [DW-1:0]     eff_h;
  logic              cfg_wr;

  logic push, pop, q_full, q_empty;
  cmd_t push_cmd, head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= DIMC_W'(512);
      cfg_height <= DIMC_W'(512);
      cfg_bg     <= CHAR_W'(32);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  cfg_width  <= pwdata[DIMC_W-1:0];
        REG_HEIGHT: cfg_height <= pwdata[DIMC_W-1:0];
        REG_BGCHAR: cfg_bg     <= pwdata[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(cfg_width);
      REG_HEIGHT: prdata = 32'(cfg_height);
      REG_BGCHAR: prdata = 32'(cfg_bg);
      default:    prdata = '0;
    endcase
  end

  assign eff_w = (32'(cfg_width) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cfg_width);
  assign eff_h = (32'(cfg_height) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cfg_height);

  rrp_front #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW)
  ) u_front (
    .req     (req),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .bg_char (cfg_bg),
    .q_full  (q_full),
    .push    (push),
    .cmd     (push_cmd)
  );

  rrp_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  rrp_back #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .rsp     (rsp)
  );
endmodule
